// File: hw/rtl/lsp_pkg.sv
package lsp_pkg;

	localparam int SENSORS = 8;
	localparam int COUNT_WIDTH_DEF = 8;
	localparam int COUNT_OUT_W = 8;
	localparam int CNT_W = $clog2(SENSORS + 1);

	typedef logic signed [5:0] pos_t;
	typedef logic signed [6:0] diff_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [SENSORS-1:0] lit_t;
	typedef logic [1:0] mode_t;

	localparam mode_t MODE_FIRST  = 2'd0;
	localparam mode_t MODE_SECOND = 2'd1;

	typedef enum logic [1:0] {
		TURN_NONE    = 2'd0,
		TURN_ALIGNED = 2'd1,
		TURN_BACK    = 2'd2,
		TURN_FORWARD = 2'd3
	} turn_t;

	localparam pos_t SIDE_W [SENSORS] = '{
		pos_t'(8), pos_t'(4), pos_t'(2), pos_t'(1),
		pos_t'(-1), pos_t'(-2), pos_t'(-4), pos_t'(-8)
	};

	localparam pos_t END_W [SENSORS] = '{
		pos_t'(8), pos_t'(6), pos_t'(4), pos_t'(2),
		pos_t'(1), pos_t'(-1), pos_t'(-2), pos_t'(-4)
	};

	localparam pos_t END_SUM  = pos_t'(8);
	localparam pos_t END_POS  = pos_t'(24);
	localparam pos_t PULL     = pos_t'(3);
	localparam cnt_t CROSS_MIN = cnt_t'(6);
	localparam cnt_t RELEASE_FIRST  = cnt_t'(2);
	localparam cnt_t RELEASE_SECOND = cnt_t'(3);

	function automatic cnt_t popcount(input lit_t lit);
		cnt_t n;
		n = '0;
		for (int i = 0; i < SENSORS; i++) begin
			n = n + cnt_t'(lit[i]);
		end
		return n;
	endfunction

	function automatic lit_t reverse(input lit_t lit);
		lit_t r;
		for (int i = 0; i < SENSORS; i++) begin
			r[i] = lit[SENSORS-1-i];
		end
		return r;
	endfunction

	function automatic pos_t pull_in(input pos_t s);
		pos_t t;
		t = s;
		if (s > 0) begin
			t = s - PULL;
			if (t < 0) t = -t;
		end else if (s < 0) begin
			t = s + PULL;
			if (t > 0) t = -t;
		end
		return t;
	endfunction

endpackage

// File: hw/rtl/lsp_side.sv
module lsp_side (
	input  lsp_pkg::lit_t lit,
	input  lsp_pkg::cnt_t cnt,
	output lsp_pkg::pos_t pos
);

	lsp_pkg::pos_t sum;
	logic          lone_end;

	always_comb begin
		sum = '0;
		for (int i = 0; i < lsp_pkg::SENSORS; i++) begin
			if (lit[i]) sum = sum + lsp_pkg::SIDE_W[i];
		end
	end

	assign lone_end = (cnt == lsp_pkg::cnt_t'(1)) &&
		((sum == lsp_pkg::END_SUM && lit[0]) ||
		 (sum == -lsp_pkg::END_SUM && lit[lsp_pkg::SENSORS-1]));

	always_comb begin
		if (lone_end) begin
			pos = sum[5] ? -lsp_pkg::END_POS : lsp_pkg::END_POS;
		end else if (cnt == lsp_pkg::cnt_t'(3)) begin
			pos = lsp_pkg::pull_in(sum);
		end else begin
			pos = sum;
		end
	end

endmodule

// File: hw/rtl/lsp_end.sv
module lsp_end (
	input  lsp_pkg::lit_t lit,
	input  lsp_pkg::cnt_t cnt,
	input  logic          mode0,
	output lsp_pkg::pos_t pos
);

	lsp_pkg::pos_t raw;
	lsp_pkg::pos_t sum;
	logic          triple;

	always_comb begin
		raw = '0;
		for (int i = 0; i < lsp_pkg::SENSORS; i++) begin
			if (lit[i]) raw = raw + lsp_pkg::END_W[i];
		end
	end

	assign sum = mode0 ? raw : -raw;

	assign triple = mode0 ?
		((sum == lsp_pkg::END_SUM && lit[0]) ||
		 (sum == -lsp_pkg::END_SUM && lit[lsp_pkg::SENSORS-1])) :
		(sum == -lsp_pkg::END_SUM && lit[0]);

	always_comb begin
		pos = sum;
		if (triple) pos = sum[5] ? -lsp_pkg::END_POS : lsp_pkg::END_POS;
		if (mode0) begin
			if (cnt == lsp_pkg::cnt_t'(3)) pos = lsp_pkg::pull_in(pos);
		end else begin
			if (cnt > lsp_pkg::cnt_t'(3)) pos = '0;
		end
	end

endmodule

// File: hw/rtl/lsp_turn.sv
module lsp_turn (
	input  lsp_pkg::pos_t  left_pos,
	input  lsp_pkg::pos_t  right_pos,
	input  lsp_pkg::cnt_t  left_cnt,
	input  lsp_pkg::cnt_t  right_cnt,
	input  lsp_pkg::mode_t mode,
	output lsp_pkg::turn_t status
);

	function automatic lsp_pkg::turn_t judge(input lsp_pkg::pos_t p, input logic m1,
			input logic left_side);
		lsp_pkg::turn_t r;
		if (m1) begin
			if (p < 3 && p > -2) r = lsp_pkg::TURN_ALIGNED;
			else if (p >= 3) r = lsp_pkg::TURN_BACK;
			else r = lsp_pkg::TURN_FORWARD;
		end else begin
			if (p < 2 && (left_side ? (p > -3) : (p >= -3))) r = lsp_pkg::TURN_ALIGNED;
			else if (p >= 3) r = lsp_pkg::TURN_BACK;
			else if (p <= -3) r = lsp_pkg::TURN_FORWARD;
			else r = lsp_pkg::TURN_NONE;
		end
		return r;
	endfunction

	logic m1;
	logic left_decides;
	logic right_decides;

	assign m1 = (mode == lsp_pkg::MODE_SECOND);
	assign left_decides = (left_cnt >= lsp_pkg::cnt_t'(1)) && (left_cnt <= lsp_pkg::cnt_t'(4))
		&& (right_cnt >= lsp_pkg::cnt_t'(1));
	assign right_decides = (right_cnt >= lsp_pkg::cnt_t'(1))
		&& (right_cnt <= lsp_pkg::cnt_t'(4)) && (left_cnt > lsp_pkg::cnt_t'(4));

	always_comb begin
		status = lsp_pkg::TURN_NONE;
		if (mode == lsp_pkg::MODE_FIRST || mode == lsp_pkg::MODE_SECOND) begin
			priority if (left_decides) status = judge(left_pos, m1, 1'b1);
			else if (right_decides) status = judge(right_pos, m1, 1'b0);
			else status = lsp_pkg::TURN_NONE;
		end
	end

endmodule

// File: hw/rtl/lsp_cross.sv
module lsp_cross #(
	parameter int COUNT_WIDTH = lsp_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   commit,
	input  logic                   clear,
	input  logic                   mode0,
	input  logic                   side_dark,
	input  lsp_pkg::cnt_t          cross_cnt,
	output logic                   seen,
	output logic [COUNT_WIDTH-1:0] count_next
);

	logic                   latch_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   latch_base;
	logic [COUNT_WIDTH-1:0] count_base;

	assign count_base = clear ? '0 : count_q;
	assign latch_base = (cross_cnt <= (mode0 ? lsp_pkg::RELEASE_FIRST : lsp_pkg::RELEASE_SECOND))
		? 1'b0 : latch_q;
	assign seen = side_dark && !latch_base && (cross_cnt >= lsp_pkg::CROSS_MIN);
	assign count_next = count_base + COUNT_WIDTH'(seen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 1'b0;
			count_q <= '0;
		end else if (commit) begin
			latch_q <= latch_base | seen;
			count_q <= count_next;
		end
	end

endmodule

// File: hw/rtl/line_sensor_position_and_crossing.sv
// An accepted request is held in the input registers and its result in the result
// registers. Throughput: one request per cycle unless out_ready stalls the output;
// each request passes the position, turn and crossing logic between those registers.
// Reset: clears the valid flags, sets the stored mode to MODE_FIRST, and clears the
// crossing latch and counter; no other wait after reset.
module line_sensor_position_and_crossing #(
	parameter int COUNT_WIDTH = lsp_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  direction_mode,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  front_pins,
	input  logic [7:0]  back_pins,
	input  logic [7:0]  left_pins,
	input  logic [7:0]  right_pins,
	input  logic        clear_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [5:0] left_position,
	output logic signed [5:0] right_position,
	output logic signed [6:0] side_difference,
	output logic signed [5:0] front_position,
	output logic signed [5:0] back_position,
	output logic signed [6:0] front_back_difference,
	output logic [1:0]  turn_status,
	output logic        crossing_seen,
	output logic [7:0]  crossing_count
);

	lsp_pkg::mode_t mode_q;

	logic          v_s1;
	lsp_pkg::lit_t front_s1, back_s1, left_s1, right_s1;
	logic          clear_s1;

	logic          v_s2;
	lsp_pkg::pos_t lp_s2, rp_s2, fp_s2, bp_s2;
	lsp_pkg::diff_t sd_s2, fbd_s2;
	lsp_pkg::turn_t turn_s2;
	logic          seen_s2;
	logic [COUNT_WIDTH-1:0] count_s2;

	logic          advance;
	logic          commit;
	logic          mode0;
	lsp_pkg::cnt_t fc, bc, lc, rc;
	lsp_pkg::pos_t lp, rp, fp, bp;
	lsp_pkg::turn_t turn;
	logic          seen;
	logic [COUNT_WIDTH-1:0] count_next;
	logic [COUNT_WIDTH+lsp_pkg::COUNT_OUT_W-1:0] count_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lsp_pkg::MODE_FIRST;
		end else if (cfg_valid) begin
			mode_q <= direction_mode;
		end
	end

	assign advance = !v_s2 || out_ready;
	assign in_ready = !v_s1 || advance;
	assign commit = v_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			front_s1 <= ~front_pins;
			back_s1  <= lsp_pkg::reverse(~back_pins);
			left_s1  <= ~left_pins;
			right_s1 <= lsp_pkg::reverse(~right_pins);
			clear_s1 <= clear_count;
		end
	end

	assign mode0 = (mode_q == lsp_pkg::MODE_FIRST);
	assign fc = lsp_pkg::popcount(front_s1);
	assign bc = lsp_pkg::popcount(back_s1);
	assign lc = lsp_pkg::popcount(left_s1);
	assign rc = lsp_pkg::popcount(right_s1);

	lsp_side u_left (.lit(left_s1), .cnt(lc), .pos(lp));
	lsp_side u_right (.lit(right_s1), .cnt(rc), .pos(rp));
	lsp_end u_front (.lit(front_s1), .cnt(fc), .mode0(mode0), .pos(fp));
	lsp_end u_back (.lit(back_s1), .cnt(bc), .mode0(mode0), .pos(bp));

	lsp_turn u_turn (
		.left_pos(lp),
		.right_pos(rp),
		.left_cnt(lc),
		.right_cnt(rc),
		.mode(mode_q),
		.status(turn)
	);

	lsp_cross #(.COUNT_WIDTH(COUNT_WIDTH)) u_cross (
		.clk(clk),
		.arst_n(arst_n),
		.commit(commit),
		.clear(clear_s1),
		.mode0(mode0),
		.side_dark((lc == '0) || (rc == '0)),
		.cross_cnt(mode0 ? bc : fc),
		.seen(seen),
		.count_next(count_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			lp_s2    <= lp;
			rp_s2    <= rp;
			fp_s2    <= fp;
			bp_s2    <= bp;
			sd_s2    <= lsp_pkg::diff_t'(lp) - lsp_pkg::diff_t'(rp);
			fbd_s2   <= mode0 ? (lsp_pkg::diff_t'(fp) - lsp_pkg::diff_t'(bp))
				: (lsp_pkg::diff_t'(bp) - lsp_pkg::diff_t'(fp));
			turn_s2  <= turn;
			seen_s2  <= seen;
			count_s2 <= count_next;
		end
	end

	assign count_ext = {{lsp_pkg::COUNT_OUT_W{1'b0}}, count_s2};

	assign out_valid             = v_s2;
	assign left_position         = lp_s2;
	assign right_position        = rp_s2;
	assign side_difference       = sd_s2;
	assign front_position        = fp_s2;
	assign back_position         = bp_s2;
	assign front_back_difference = fbd_s2;
	assign turn_status           = turn_s2;
	assign crossing_seen         = seen_s2;
	assign crossing_count        = count_ext[lsp_pkg::COUNT_OUT_W-1:0];

endmodule

// File: tb/sv/line_sensor_position_and_crossing_monitor.sv
`timescale 1ns / 1ps

module line_sensor_position_and_crossing_monitor
	import lsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  direction_mode,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  front_pins,
	input  logic [7:0]  back_pins,
	input  logic [7:0]  left_pins,
	input  logic [7:0]  right_pins,
	input  logic        clear_count,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic signed [5:0] left_position,
	input  logic signed [5:0] right_position,
	input  logic signed [6:0] side_difference,
	input  logic signed [5:0] front_position,
	input  logic signed [5:0] back_position,
	input  logic signed [6:0] front_back_difference,
	input  logic [1:0]  turn_status,
	input  logic        crossing_seen,
	input  logic [7:0]  crossing_count,
	output int          errors,
	output int          pending
);

	localparam int SIDE_WT  [8] = '{8, 4, 2, 1, -1, -2, -4, -8};
	localparam int FRONT_WT [8] = '{8, 6, 4, 2, 1, -1, -2, -4};
	localparam int BACK_WT  [8] = '{-4, -2, -1, 1, 2, 4, 6, 8};
	localparam int PRINT_CAP = 50;

	typedef struct {
		pos_t       lp;
		pos_t       rp;
		diff_t      sd;
		pos_t       fp;
		pos_t       bp;
		diff_t      fbd;
		turn_t      turn;
		logic       seen;
		logic [7:0] count;
	} scan_result_t;

	scan_result_t predicted_scans[$];
	mode_t        mode = MODE_FIRST;
	logic         cross_latched = 1'b0;
	logic [7:0]   cross_total = '0;

	function automatic int side_sum(lit_t lit);
		int s;
		s = 0;
		for (int i = 0; i < 8; i++) if (lit[i]) s += SIDE_WT[i];
		return s;
	endfunction

	function automatic int front_sum(lit_t lit);
		int s;
		s = 0;
		for (int i = 0; i < 8; i++) if (lit[i]) s += FRONT_WT[i];
		return s;
	endfunction

	function automatic int back_sum(lit_t lit);
		int s;
		s = 0;
		for (int i = 0; i < 8; i++) if (lit[i]) s += BACK_WT[i];
		return s;
	endfunction

	// move 3 toward zero; past zero keep the old sign
	function automatic int toward_center(int s);
		int t;
		t = s;
		if (s > 0) begin
			t = s - 3;
			if (t < 0) t = -t;
		end else if (s < 0) begin
			t = s + 3;
			if (t > 0) t = -t;
		end
		return t;
	endfunction

	function automatic turn_t grade_turn(int p, bit second, bit from_left);
		if (second) begin
			if (p < 3 && p > -2) return TURN_ALIGNED;
			if (p >= 3) return TURN_BACK;
			return TURN_FORWARD;
		end
		if (from_left ? (p < 2 && p > -3) : (p < 2 && p >= -3)) return TURN_ALIGNED;
		if (p >= 3) return TURN_BACK;
		if (p <= -3) return TURN_FORWARD;
		return TURN_NONE;
	endfunction

	function automatic scan_result_t predict_scan(lit_t fl, lit_t bl, lit_t ll, lit_t rl,
			logic clr);
		int fc, bc, lc, rc, lp, rp, fp, bp, fbd, cross_n;
		scan_result_t r;
		fc = $countones(fl);
		bc = $countones(bl);
		lc = $countones(ll);
		rc = $countones(rl);
		if (clr) cross_total = '0;

		lp = side_sum(ll);
		if (lc == 1 && ((lp == 8 && ll[0]) || (lp == -8 && ll[7]))) lp = lp * 3;
		if (lc == 3) lp = toward_center(lp);
		rp = -side_sum(rl);
		if (rc == 1 && ((rp == 8 && rl[7]) || (rp == -8 && rl[0]))) rp = rp * 3;
		if (rc == 3) rp = toward_center(rp);

		r.turn = TURN_NONE;
		if (mode == MODE_FIRST || mode == MODE_SECOND) begin
			if (lc >= 1 && lc <= 4 && rc >= 1)
				r.turn = grade_turn(lp, mode == MODE_SECOND, 1'b1);
			else if (rc >= 1 && rc <= 4 && lc > 4)
				r.turn = grade_turn(rp, mode == MODE_SECOND, 1'b0);
		end

		if (mode == MODE_FIRST) begin
			fp = front_sum(fl);
			bp = back_sum(bl);
			if ((fp == 8 && fl[0]) || (fp == -8 && fl[7])) fp = fp * 3;
			if ((bp == 8 && bl[7]) || (bp == -8 && bl[0])) bp = bp * 3;
			if (fc == 3) fp = toward_center(fp);
			if (bc == 3) bp = toward_center(bp);
			fbd = fp - bp;
			cross_n = bc;
			if (bc <= 2) cross_latched = 1'b0;
		end else begin
			fp = -front_sum(fl);
			bp = -back_sum(bl);
			if (fp == -8 && fl[0]) fp = fp * 3;
			if (bp == -8 && bl[7]) bp = bp * 3;
			if (fc > 3) fp = 0;
			if (bc > 3) bp = 0;
			fbd = bp - fp;
			cross_n = fc;
			if (fc <= 3) cross_latched = 1'b0;
		end

		r.seen = 1'b0;
		if ((lc == 0 || rc == 0) && !cross_latched && cross_n >= 6) begin
			r.seen = 1'b1;
			cross_latched = 1'b1;
			cross_total = cross_total + 8'd1;
		end

		r.lp = pos_t'(lp);
		r.rp = pos_t'(rp);
		r.sd = diff_t'(lp - rp);
		r.fp = pos_t'(fp);
		r.bp = pos_t'(bp);
		r.fbd = diff_t'(fbd);
		r.count = cross_total;
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		if (errors < PRINT_CAP)
			$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		if (!arst_n) begin
			mode = MODE_FIRST;
			cross_latched = 1'b0;
			cross_total = '0;
			predicted_scans.delete();
		end else begin
			if (cfg_valid && cfg_ready) mode = direction_mode;
			if (in_valid && in_ready)
				predicted_scans.push_back(predict_scan(~front_pins, ~back_pins, ~left_pins,
					~right_pins, clear_count));
			if (out_valid && out_ready) begin
				if (predicted_scans.size() == 0) begin
					report("result with no request pending", 1, 0);
				end else begin
					want = predicted_scans.pop_front();
					if (left_position != want.lp)
						report("left_position", left_position, want.lp);
					if (right_position != want.rp)
						report("right_position", right_position, want.rp);
					if (side_difference != want.sd)
						report("side_difference", side_difference, want.sd);
					if (front_position != want.fp)
						report("front_position", front_position, want.fp);
					if (back_position != want.bp)
						report("back_position", back_position, want.bp);
					if (front_back_difference != want.fbd)
						report("front_back_difference", front_back_difference, want.fbd);
					if (turn_status != want.turn)
						report("turn_status", int'(turn_status), int'(want.turn));
					if (crossing_seen != want.seen)
						report("crossing_seen", int'(crossing_seen), int'(want.seen));
					if (crossing_count != want.count)
						report("crossing_count", int'(crossing_count), int'(want.count));
				end
			end
		end
		pending = predicted_scans.size();
	end

endmodule

// File: tb/sv/line_sensor_position_and_crossing_tb.sv
`timescale 1ns / 1ps

module line_sensor_position_and_crossing_tb;

	import lsp_pkg::*;

	localparam mode_t MODE_THIRD  = 2'd2;
	localparam mode_t MODE_FOURTH = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 200;
	localparam int TAIL_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	mode_t      direction_mode = MODE_FIRST;
	logic       in_valid = 1'b0;
	logic [7:0] front_pins = 8'hFF;
	logic [7:0] back_pins = 8'hFF;
	logic [7:0] left_pins = 8'hFF;
	logic [7:0] right_pins = 8'hFF;
	logic       clear_count = 1'b0;
	logic       out_ready = 1'b0;

	logic        cfg_ready, in_ready, out_valid;
	logic signed [5:0] left_position, right_position, front_position, back_position;
	logic signed [6:0] side_difference, front_back_difference;
	logic [1:0]  turn_status;
	logic        crossing_seen;
	logic [7:0]  crossing_count;

	int    errors, pending;
	int    scans_sent = 0;
	bit    gaps_on = 1'b1;
	bit    hold_req = 1'b0;
	mode_t cur_mode = MODE_FIRST;

	always #6 clk = ~clk;

	line_sensor_position_and_crossing uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .direction_mode(direction_mode),
		.in_valid(in_valid), .in_ready(in_ready),
		.front_pins(front_pins), .back_pins(back_pins),
		.left_pins(left_pins), .right_pins(right_pins), .clear_count(clear_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.left_position(left_position), .right_position(right_position),
		.side_difference(side_difference),
		.front_position(front_position), .back_position(back_position),
		.front_back_difference(front_back_difference),
		.turn_status(turn_status), .crossing_seen(crossing_seen),
		.crossing_count(crossing_count)
	);

	line_sensor_position_and_crossing_monitor scan_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .direction_mode(direction_mode),
		.in_valid(in_valid), .in_ready(in_ready),
		.front_pins(front_pins), .back_pins(back_pins),
		.left_pins(left_pins), .right_pins(right_pins), .clear_count(clear_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.left_position(left_position), .right_position(right_position),
		.side_difference(side_difference),
		.front_position(front_position), .back_position(back_position),
		.front_back_difference(front_back_difference),
		.turn_status(turn_status), .crossing_seen(crossing_seen),
		.crossing_count(crossing_count),
		.errors(errors), .pending(pending)
	);

	function automatic logic [7:0] heavy_pins(int max_dark);
		logic [7:0] p;
		p = 8'h00;
		repeat ($urandom_range(0, max_dark)) p[$urandom_range(0, 7)] = 1'b1;
		return p;
	endfunction

	function automatic logic [7:0] few_lit(int max_lit);
		logic [7:0] p;
		p = 8'hFF;
		repeat ($urandom_range(0, max_lit)) p[$urandom_range(0, 7)] = 1'b0;
		return p;
	endfunction

	function automatic logic [7:0] rand_pins();
		logic [7:0] p;
		int n;
		p = 8'hFF;
		case ($urandom_range(0, 5))
			0: p = 8'hFF;
			1: p[$urandom_range(0, 7)] = 1'b0;
			2: p = ~(8'h03 << $urandom_range(0, 6));
			3: p = 8'($urandom());
			4: p = heavy_pins(3);
			default: begin
				n = $urandom_range(3, 4);
				while ($countones(~p) < n) p[$urandom_range(0, 7)] = 1'b0;
			end
		endcase
		return p;
	endfunction

	task automatic send_scan(logic [7:0] f, logic [7:0] b, logic [7:0] l, logic [7:0] r,
			logic clr);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		front_pins <= f;
		back_pins <= b;
		left_pins <= l;
		right_pins <= r;
		clear_count <= clr;
		scans_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_mode(mode_t m);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		cfg_valid <= 1'b1;
		direction_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_mode = m;
	endtask

	// cross the line with the sensing array, then drop it back to a few lit sensors
	task automatic send_crossing(bit strict);
		logic [7:0] heavy, calm, dark, lit_side, other, f_pins, b_pins, l_pins, r_pins;
		logic clr;
		heavy = heavy_pins(strict ? 2 : 3);
		calm = few_lit(strict ? (cur_mode == MODE_FIRST ? 2 : 3) : 4);
		dark = (strict || $urandom_range(0, 5) != 0) ? 8'hFF : rand_pins();
		lit_side = rand_pins();
		other = rand_pins();
		clr = !strict && $urandom_range(0, 15) == 0;
		if ($urandom_range(0, 1)) begin
			l_pins = dark;
			r_pins = lit_side;
		end else begin
			l_pins = lit_side;
			r_pins = dark;
		end
		f_pins = (cur_mode == MODE_FIRST) ? other : heavy;
		b_pins = (cur_mode == MODE_FIRST) ? heavy : other;
		repeat (strict ? 1 : $urandom_range(1, 2)) send_scan(f_pins, b_pins, l_pins, r_pins, clr);
		f_pins = (cur_mode == MODE_FIRST) ? other : calm;
		b_pins = (cur_mode == MODE_FIRST) ? calm : other;
		send_scan(f_pins, b_pins, l_pins, r_pins, 1'b0);
	endtask

	task automatic run_mix(int count);
		int stop;
		stop = scans_sent + count;
		while (scans_sent < stop) begin
			if ($urandom_range(0, 9) < 6)
				send_crossing(1'b0);
			else
				send_scan(rand_pins(), rand_pins(), rand_pins(), rand_pins(),
					$urandom_range(0, 31) == 0);
		end
	endtask

	initial begin : result_side
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("line_sensor_position_and_crossing_tb failed");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_scan(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_scan(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		send_scan(8'hFE, 8'h7F, 8'hFE, 8'h7F, 1'b0);
		send_scan(8'h1F, 8'hF8, 8'h7F, 8'hFE, 1'b0);
		send_scan(8'hCE, 8'h73, 8'hC7, 8'hF7, 1'b0);
		send_scan(8'hFF, 8'hFF, 8'hFB, 8'hFE, 1'b0);
		send_scan(8'hFF, 8'hFF, 8'hCF, 8'h7F, 1'b0);
		send_scan(8'hFF, 8'hFF, 8'h00, 8'hF3, 1'b0);
		send_scan(8'hFF, 8'hFF, 8'h00, 8'hDF, 1'b0);
		send_scan(8'hFF, 8'hFF, 8'h00, 8'hFD, 1'b0);
		send_scan(8'hFF, 8'hC0, 8'hFF, 8'h5A, 1'b0);
		send_scan(8'hFF, 8'hC0, 8'hFF, 8'h5A, 1'b0);
		send_scan(8'hFF, 8'hF8, 8'hFF, 8'h5A, 1'b0);
		send_scan(8'hFF, 8'hC0, 8'hFF, 8'h5A, 1'b0);
		send_scan(8'hFF, 8'h7E, 8'hFF, 8'h5A, 1'b0);
		send_scan(8'hA5, 8'h01, 8'h00, 8'hFF, 1'b1);
		send_scan(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_scan(8'hFF, 8'hE0, 8'hFF, 8'h00, 1'b0);
		send_scan(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);

		write_mode(MODE_SECOND);
		send_scan(8'hFE, 8'h7F, 8'h7F, 8'hFE, 1'b0);
		send_scan(8'hF0, 8'h0F, 8'hF7, 8'hFE, 1'b0);
		send_scan(8'hC0, 8'hFF, 8'hFF, 8'h00, 1'b0);
		send_scan(8'hF8, 8'hFF, 8'hFB, 8'hFE, 1'b0);
		send_scan(8'hFF, 8'hFF, 8'hDF, 8'hFE, 1'b0);

		write_mode(MODE_FOURTH);
		hold_req = 1'b1;
		run_mix(150);
		write_mode(MODE_FIRST);
		run_mix(200);
		write_mode(MODE_THIRD);
		repeat (258) send_crossing(1'b1);
		write_mode(MODE_SECOND);
		gaps_on = 1'b0;
		run_mix(100);
		in_valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("line_sensor_position_and_crossing_tb passed");
		else
			$display("line_sensor_position_and_crossing_tb failed");
		$finish;
	end

endmodule
